FILE: rtl/swrm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window rate monitor package
// Shared types, field widths and constants for the rate monitor block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swrm_pkg;

  // Width of the channel field on the input channel.
  localparam int CH_W = 4;

  // Bit-serial divider sizes: numerator magnitude and divisor magnitude.
  localparam int DIV_NW = 40;
  localparam int DIV_DW = 33;
  localparam int DIV_CW = $clog2(DIV_NW);

  // Arithmetic constants.
  localparam logic signed [32:0] ZERO_DT_DIVISOR = 33'sd1000000;
  localparam logic signed [32:0] HOUR_SECONDS    = 33'sd3600;

  // Action codes.
  localparam logic ACT_INIT = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  // Window codes.
  localparam logic WIN_MINUTE = 1'b0;
  localparam logic WIN_HOUR   = 1'b1;

  // One input transaction.
  typedef struct packed {
    logic              action;
    logic [CH_W-1:0]   channel;
    logic              last_channel;
    logic signed [31:0] now_seconds;
    logic signed [31:0] in_count;
    logic signed [31:0] out_count;
    logic signed [31:0] dropped_count;
    logic signed [31:0] wait_sum;
    logic signed [31:0] wait_num;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic              window;
    logic signed [31:0] in_rate;
    logic signed [31:0] out_rate;
    logic signed [31:0] dropped_rate;
    logic signed [31:0] avg_wait;
    logic signed [31:0] max_in;
    logic signed [31:0] max_out;
    logic signed [31:0] max_dropped;
    logic signed [31:0] max_wait;
    logic              last;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_READ,
    ST_LOAD,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_FIN
  } state_t;

  // Turns a quotient magnitude and its sign into a saturated 32-bit value.
  function automatic logic [31:0] sat_quo(input logic [DIV_NW-1:0] q, input logic neg);
    logic [31:0] r;
    if (!neg) begin
      r = (|q[DIV_NW-1:31]) ? 32'h7fff_ffff : q[31:0];
    end else begin
      r = ((|q[DIV_NW-1:32]) || (q[31] && (|q[30:0]))) ? 32'h8000_0000 : (32'd0 - q[31:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/swrm_if.sv
// ----------------------------------------------------------------------------
// Sliding window rate monitor channel interfaces
// Valid/ready channels that carry input and result transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swrm_in_if import swrm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface swrm_out_if import swrm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/swrm_div.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrm_div import swrm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] num_mag,
  input  wire logic [DIV_DW-1:0] den_mag,
  output logic                   done,
  output logic [DIV_NW-1:0]      quo
);

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;

  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_sub;
  logic              ge;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_NW-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
  end

  // Control: step count and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the numerator shifts out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num_mag;
      rem_r <= '0;
      den_r <= den_mag;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NW-2:0], ge};
      rem_r <= ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

FILE: rtl/sliding_window_rate_monitor_core.sv
// ----------------------------------------------------------------------------
// Sliding window rate monitor core
// Per-channel snapshot ring with minute and hour rates, averages and maxima.
// ----------------------------------------------------------------------------
// Sequence: a poll gives its minute result and then its hour result; each window
// runs the read, load, prep, start, divide and finish states, and an init runs
// the init state. A new transaction is taken only once the hour result is in the
// output register; the 40-step bit-serial dividers (four lanes) run once per window.
// Reset: synchronous active-low; clears ring pointer, fill count, maxima
// valid bits and the output valid bit. Snapshot memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_rate_monitor_core import swrm_pkg::*; #(
  parameter int SLOTS    = 60,
  parameter int CHANNELS = 14
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  swrm_in_if.sink      in_chan,
  swrm_out_if.source   out_chan
);

  localparam int SW      = $clog2(SLOTS + 1);
  localparam int PW      = $clog2(SLOTS);
  localparam int RAW     = SW + CH_W;
  localparam int RDEPTH  = (SLOTS + 1) << CH_W;
  localparam int MAW     = CH_W + 1;
  localparam int MDEPTH  = 1 << MAW;

  state_t state_r, state_nxt;

  in_item_t       item_r;
  logic [PW-1:0]  ptr_r;
  logic [SW-1:0]  filled_r;
  logic           win_r;

  // Memories: ring and base snapshots, slot times, per-window maxima.
  logic [159:0] ring_mem [RDEPTH];
  logic [31:0]  time_mem [SLOTS + 1];
  logic [127:0] max_mem  [MDEPTH];
  logic [MDEPTH-1:0] max_vld_r;

  logic [159:0] ring_q_r;
  logic [31:0]  time_q_r;
  logic [127:0] max_q_r;
  logic         max_vld_q_r;

  logic signed [32:0] diff_r [3];
  logic signed [32:0] dsum_r;
  logic signed [32:0] dnum_r;
  logic signed [32:0] dt_r;
  logic signed [39:0] num_r [4];
  logic signed [32:0] den_r [4];
  logic               mean_zero_r;
  logic [3:0]         neg_r;

  logic [DIV_NW-1:0]  num_mag [4];
  logic [DIV_DW-1:0]  den_mag [4];
  logic [DIV_NW-1:0]  quo [4];
  logic [3:0]         div_done;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic              accept;
  logic              fin_fire;
  logic              div_start;
  logic [PW-1:0]     newest;
  logic [PW-1:0]     idx;
  logic [SW-1:0]     slot_s;
  logic [RAW-1:0]    rd_addr;
  logic [MAW-1:0]    max_addr;
  logic [127:0]      max_old;
  logic [31:0]       res [4];
  logic [31:0]       max_new [4];
  logic              max_upd;
  logic [127:0]      max_emit;

  // Slot selection for the current window.
  always_comb begin
    newest   = (ptr_r == '0) ? PW'(SLOTS - 1) : ptr_r - 1'b1;
    idx      = (win_r == WIN_HOUR) ? ptr_r : newest;
    slot_s   = (SW'(idx) < filled_r) ? SW'(idx) : SW'(SLOTS);
    rd_addr  = {slot_s, item_r.channel};
    max_addr = {win_r, item_r.channel};
  end

  // Sequencer next state and strobes.
  always_comb begin
    state_nxt = state_r;
    accept    = 1'b0;
    fin_fire  = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        accept = in_chan.valid;
        if (in_chan.valid && (7'(in_chan.data.channel) < 7'(CHANNELS))) begin
          state_nxt = (in_chan.data.action == ACT_INIT) ? ST_INIT : ST_READ;
        end
      end
      ST_INIT:  state_nxt = ST_IDLE;
      ST_READ:  state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_START;
      ST_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (&div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          fin_fire  = 1'b1;
          state_nxt = (win_r == WIN_HOUR) ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_chan.ready = (state_r == ST_IDLE);

  // Control registers: ring pointer, fill count, window, maxima valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      filled_r  <= '0;
      win_r     <= WIN_MINUTE;
      max_vld_r <= '0;
    end else begin
      if (accept) begin
        win_r <= WIN_MINUTE;
      end
      if (state_r == ST_INIT) begin
        ptr_r    <= '0;
        filled_r <= '0;
        max_vld_r[{WIN_MINUTE, item_r.channel}] <= 1'b0;
        max_vld_r[{WIN_HOUR, item_r.channel}]   <= 1'b0;
      end
      if (fin_fire) begin
        if (max_upd) begin
          max_vld_r[max_addr] <= 1'b1;
        end
        if (win_r == WIN_MINUTE) begin
          win_r <= WIN_HOUR;
        end else if (item_r.last_channel) begin
          ptr_r <= (ptr_r == PW'(SLOTS - 1)) ? '0 : ptr_r + 1'b1;
          if (filled_r < SW'(SLOTS)) begin
            filled_r <= filled_r + 1'b1;
          end
        end
      end
    end
  end

  // Transaction capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_chan.data;
    end
  end

  // Snapshot memories: base write on init, ring write after the hour window.
  always_ff @(posedge clk) begin
    if (state_r == ST_INIT) begin
      ring_mem[{SW'(SLOTS), item_r.channel}] <= {item_r.wait_num, item_r.wait_sum,
          item_r.dropped_count, item_r.out_count, item_r.in_count};
      time_mem[SLOTS] <= item_r.now_seconds;
    end else if (fin_fire && (win_r == WIN_HOUR)) begin
      ring_mem[{SW'(ptr_r), item_r.channel}] <= {item_r.wait_num, item_r.wait_sum,
          item_r.dropped_count, item_r.out_count, item_r.in_count};
      if (item_r.last_channel) begin
        time_mem[ptr_r] <= item_r.now_seconds;
      end
    end
    ring_q_r <= ring_mem[rd_addr];
    time_q_r <= time_mem[slot_s];
  end

  // Maxima memory.
  always_ff @(posedge clk) begin
    if (fin_fire && max_upd) begin
      max_mem[max_addr] <= max_emit;
    end
    max_q_r     <= max_mem[max_addr];
    max_vld_q_r <= max_vld_r[max_addr];
  end

  // Differences against the selected slot.
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      diff_r[0] <= $signed({item_r.in_count[31], item_r.in_count})
                 - $signed({ring_q_r[31], ring_q_r[31:0]});
      diff_r[1] <= $signed({item_r.out_count[31], item_r.out_count})
                 - $signed({ring_q_r[63], ring_q_r[63:32]});
      diff_r[2] <= $signed({item_r.dropped_count[31], item_r.dropped_count})
                 - $signed({ring_q_r[95], ring_q_r[95:64]});
      dsum_r    <= $signed({item_r.wait_sum[31], item_r.wait_sum})
                 - $signed({ring_q_r[127], ring_q_r[127:96]});
      dnum_r    <= $signed({item_r.wait_num[31], item_r.wait_num})
                 - $signed({ring_q_r[159], ring_q_r[159:128]});
      dt_r      <= $signed({item_r.now_seconds[31], item_r.now_seconds})
                 - $signed({time_q_r[31], time_q_r});
    end
  end

  // Numerators and divisors: rates scale by 60, the mean rounds by half.
  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      for (int k = 0; k < 3; k++) begin
        num_r[k] <= ($signed({{7{diff_r[k][32]}}, diff_r[k]}) <<< 6)
                  - ($signed({{7{diff_r[k][32]}}, diff_r[k]}) <<< 2);
        den_r[k] <= (dt_r == '0) ? ZERO_DT_DIVISOR : dt_r;
      end
      num_r[3]    <= $signed({{7{dsum_r[32]}}, dsum_r})
                   + $signed({{8{dnum_r[32]}}, dnum_r[32:1]});
      den_r[3]    <= (dnum_r[32] || (dnum_r == '0)) ? 33'sd1 : dnum_r;
      mean_zero_r <= dnum_r[32] || (dnum_r == '0);
    end
  end

  // Magnitudes into the divider lanes; the result sign is kept aside.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      num_mag[k] = num_r[k][39] ? DIV_NW'(-num_r[k]) : DIV_NW'(num_r[k]);
      den_mag[k] = den_r[k][32] ? DIV_DW'(-den_r[k]) : DIV_DW'(den_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      for (int k = 0; k < 4; k++) begin
        neg_r[k] <= num_r[k][39] ^ den_r[k][32];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    swrm_div u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (div_start),
      .num_mag (num_mag[g]),
      .den_mag (den_mag[g]),
      .done    (div_done[g]),
      .quo     (quo[g])
    );
  end

  // Saturated results and running maxima.
  always_comb begin
    max_old = max_vld_q_r ? max_q_r : '0;
    for (int k = 0; k < 4; k++) begin
      res[k] = sat_quo(quo[k], neg_r[k]);
    end
    if (mean_zero_r) begin
      res[3] = '0;
    end
    for (int k = 0; k < 4; k++) begin
      max_new[k] = ($signed(res[k]) > $signed(max_old[32*k +: 32])) ? res[k]
                                                                     : max_old[32*k +: 32];
    end
    max_upd  = (win_r == WIN_MINUTE) || (dt_r >= HOUR_SECONDS);
    max_emit = max_upd ? {max_new[3], max_new[2], max_new[1], max_new[0]} : max_old;
  end

  // Output register parts the result side from the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_data_r.window       <= win_r;
      out_data_r.in_rate      <= res[0];
      out_data_r.out_rate     <= res[1];
      out_data_r.dropped_rate <= res[2];
      out_data_r.avg_wait     <= res[3];
      out_data_r.max_in       <= max_emit[31:0];
      out_data_r.max_out      <= max_emit[63:32];
      out_data_r.max_dropped  <= max_emit[95:64];
      out_data_r.max_wait     <= max_emit[127:96];
      out_data_r.last         <= win_r;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // The ring pointer always names a ring slot.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r < PW'(SLOTS)) else $error("ring pointer out of range");

  // The fill count never passes the ring size.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= SW'(SLOTS)) else $error("fill count out of range");

  // A result is loaded only into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire |-> (!out_valid_r || out_chan.ready)) else $error("result overwritten");

  // Divider completion is only seen while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done[0] |-> (state_r == ST_DIV)) else $error("unexpected divider completion");

  // The hour window follows the minute window of the same poll.
  a_win_order: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_fire && (win_r == WIN_MINUTE)) |=> (state_r == ST_READ) && (win_r == WIN_HOUR))
    else $error("hour window did not follow");

endmodule

`default_nettype wire

FILE: tb/swrm_checker.sv
// ----------------------------------------------------------------------------
// Rate monitor result checker
// Watches both channels of the rate monitor. It keeps its own copy of the
// snapshot ring and the maxima, works out the two expected results of every
// accepted poll, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swrm_checker import swrm_pkg::*; #(
  parameter int SLOTS    = 60,
  parameter int CHANNELS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  swrm_in_if.sink   in_mon,
  swrm_out_if.sink  out_mon,
  output int        fail_count,
  output int        pending,
  output int        polls_seen,
  output int        results_seen
);

  // Mirror of the block state.
  int unsigned ring_ptr;
  int unsigned filled;
  longint      snap_time [0:SLOTS];
  longint      snap_cnt  [0:SLOTS][0:CHANNELS-1][0:4];
  logic signed [31:0] min_peak  [0:CHANNELS-1][0:3];
  logic signed [31:0] hour_peak [0:CHANNELS-1][0:3];

  out_item_t expected_results [$];

  assign pending = expected_results.size();

  // Saturates a 64-bit value to signed 32 bits.
  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] scale_rate(longint diff, longint dt);
    longint d;
    d = (dt == 0) ? 64'sd1000000 : dt;
    return clamp32((diff * 60) / d);
  endfunction

  // Rates and mean wait against one ring slot; returns elapsed seconds.
  function automatic longint window_rates(int unsigned idx, int ch, longint now,
                                          longint cur [0:4],
                                          output logic signed [31:0] r [0:3]);
    int unsigned s;
    longint n;
    s = (idx < filled) ? idx : SLOTS;
    for (int k = 0; k < 3; k++) r[k] = scale_rate(cur[k] - snap_cnt[s][ch][k], now - snap_time[s]);
    n = cur[4] - snap_cnt[s][ch][4];
    r[3] = (n <= 0) ? 32'sd0 : clamp32((cur[3] - snap_cnt[s][ch][3] + n / 2) / n);
    return now - snap_time[s];
  endfunction

  function automatic out_item_t pack_result(logic win, logic signed [31:0] r [0:3],
                                            logic signed [31:0] m [0:3]);
    out_item_t o;
    o.window = win;
    o.in_rate = r[0]; o.out_rate = r[1]; o.dropped_rate = r[2]; o.avg_wait = r[3];
    o.max_in = m[0]; o.max_out = m[1]; o.max_dropped = m[2]; o.max_wait = m[3];
    o.last = win;
    return o;
  endfunction

  // Applies one accepted transaction to the mirror and queues its results.
  task automatic predict_rates(in_item_t it);
    int ch;
    longint now, dt_hour;
    longint cur [0:4];
    logic signed [31:0] r1 [0:3];
    logic signed [31:0] r60 [0:3];
    int unsigned oldest, newest;
    ch = it.channel;
    if (ch >= CHANNELS) return;
    now = it.now_seconds;
    cur[0] = it.in_count; cur[1] = it.out_count; cur[2] = it.dropped_count;
    cur[3] = it.wait_sum; cur[4] = it.wait_num;
    if (it.action == ACT_INIT) begin
      snap_cnt[SLOTS][ch] = cur;
      snap_time[SLOTS] = now;
      ring_ptr = 0;
      filled = 0;
      for (int k = 0; k < 4; k++) begin
        min_peak[ch][k] = '0;
        hour_peak[ch][k] = '0;
      end
      return;
    end
    polls_seen++;
    oldest = (ring_ptr < SLOTS) ? ring_ptr : 0;
    newest = (oldest == 0) ? SLOTS - 1 : oldest - 1;
    void'(window_rates(newest, ch, now, cur, r1));
    dt_hour = window_rates(oldest, ch, now, cur, r60);
    snap_cnt[oldest][ch] = cur;
    for (int k = 0; k < 4; k++) begin
      if (r1[k] > min_peak[ch][k]) min_peak[ch][k] = r1[k];
      if (dt_hour >= 3600 && r60[k] > hour_peak[ch][k]) hour_peak[ch][k] = r60[k];
    end
    if (it.last_channel) begin
      snap_time[oldest] = now;
      ring_ptr = (oldest + 1 >= SLOTS) ? 0 : oldest + 1;
      if (filled < SLOTS) filled++;
    end
    expected_results.push_back(pack_result(WIN_MINUTE, r1, min_peak[ch]));
    expected_results.push_back(pack_result(WIN_HOUR, r60, hour_peak[ch]));
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t e;
    if (expected_results.size() == 0) begin
      $display("[%0t] result transaction with no poll waiting", $realtime);
      fail_count++;
      return;
    end
    e = expected_results.pop_front();
    if (got.window !== e.window) report_mismatch("window", got.window, e.window);
    if (got.in_rate !== e.in_rate) report_mismatch("in_rate", got.in_rate, e.in_rate);
    if (got.out_rate !== e.out_rate) report_mismatch("out_rate", got.out_rate, e.out_rate);
    if (got.dropped_rate !== e.dropped_rate)
      report_mismatch("dropped_rate", got.dropped_rate, e.dropped_rate);
    if (got.avg_wait !== e.avg_wait) report_mismatch("avg_wait", got.avg_wait, e.avg_wait);
    if (got.max_in !== e.max_in) report_mismatch("max_in", got.max_in, e.max_in);
    if (got.max_out !== e.max_out) report_mismatch("max_out", got.max_out, e.max_out);
    if (got.max_dropped !== e.max_dropped)
      report_mismatch("max_dropped", got.max_dropped, e.max_dropped);
    if (got.max_wait !== e.max_wait) report_mismatch("max_wait", got.max_wait, e.max_wait);
    if (got.last !== e.last) report_mismatch("last", got.last, e.last);
  endtask

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      ring_ptr <= 0;
      filled <= 0;
      for (int c = 0; c < CHANNELS; c++)
        for (int k = 0; k < 4; k++) begin
          min_peak[c][k] = '0;
          hour_peak[c][k] = '0;
        end
    end else begin
      if (in_mon.valid && in_mon.ready) predict_rates(in_mon.data);
      if (out_mon.valid && out_mon.ready) begin
        results_seen++;
        check_result(out_mon.data);
      end
    end
  end

  initial begin
    fail_count = 0;
    polls_seen = 0;
    results_seen = 0;
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Rate monitor testbench
// Drives init and poll transactions in sessions of full polling rounds over
// a random set of channels, mixed with noise, and gives the verdict from the
// checker's failure and pending counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import swrm_pkg::*;

  localparam int CHANNELS = 14;
  localparam int ITEM_GOAL = 550;
  localparam int CALM_FROM = 490;
  localparam int IDLE_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  swrm_in_if  in_chan ();
  swrm_out_if out_chan ();

  int fail_count, pending, polls_seen, results_seen;
  int items_sent;
  int idle_cycles;
  logic calm;

  // Running counters and clock of the simulated statistics source.
  longint now_s;
  logic signed [31:0] counters [0:CHANNELS-1][0:4];

  sliding_window_rate_monitor_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  swrm_checker #(.CHANNELS(CHANNELS)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .fail_count   (fail_count),
    .pending      (pending),
    .polls_seen   (polls_seen),
    .results_seen (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: ready stalls in random bursts, none near the end.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  // Watchdog on cycles where no transaction moves on either channel.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Presents one transaction and holds it until accepted. Valid stays high
  // into the next transaction unless an idle burst drops it.
  task automatic send_item(in_item_t it);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data <= it;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    if (it.channel < CHANNELS) items_sent++;
    if (items_sent >= CALM_FROM) calm = 1'b1;
  endtask

  function automatic in_item_t make_item(logic act, int ch, logic lastc);
    in_item_t it;
    it.action = act;
    it.channel = CH_W'(ch);
    it.last_channel = lastc;
    it.now_seconds = now_s[31:0];
    it.in_count = counters[ch][0];
    it.out_count = counters[ch][1];
    it.dropped_count = counters[ch][2];
    it.wait_sum = counters[ch][3];
    it.wait_num = counters[ch][4];
    return it;
  endfunction

  // Moves one channel's counters on; now and then to an arbitrary value.
  task automatic bump_counters(int ch);
    for (int k = 0; k < 5; k++) begin
      if ($urandom_range(0, 19) == 0)
        counters[ch][k] = $urandom;
      else
        counters[ch][k] = counters[ch][k] + $urandom_range(0, 3000);
    end
  endtask

  task automatic step_clock();
    case ($urandom_range(0, 19))
      0:       now_s = now_s;
      1:       now_s = now_s - $urandom_range(1, 120);
      2:       now_s = now_s + $urandom_range(3600, 9000);
      3:       now_s = $signed($urandom);
      default: now_s = now_s + $urandom_range(50, 70);
    endcase
  endtask

  task automatic send_noise();
    in_item_t it;
    it.action = 1'($urandom);
    it.last_channel = 1'($urandom);
    {it.now_seconds, it.in_count, it.out_count} = {$urandom, $urandom, $urandom};
    {it.dropped_count, it.wait_sum, it.wait_num} = {$urandom, $urandom, $urandom};
    it.channel = CH_W'($urandom_range(CHANNELS, 15));
    send_item(it);
  endtask

  int active [$];
  int order [$];
  int n_active;

  initial begin
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    calm = 1'b0;
    items_sent = 0;
    idle_cycles = 0;
    now_s = 1000;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: extreme bases on every channel, then polls that saturate.
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < 5; k++)
        counters[c][k] = (c % 3 == 0) ? 32'sh7fff_ffff : (c % 3 == 1) ? 32'sh8000_0000 : 0;
      send_item(make_item(ACT_INIT, c, c[0]));
    end
    send_noise();
    send_noise();
    // Zero elapsed time, then huge swings both ways.
    for (int k = 0; k < 5; k++) begin
      counters[0][k] = 32'sh8000_0000;
      counters[13][k] = 32'sh7fff_ffff;
    end
    send_item(make_item(ACT_POLL, 0, 1'b0));
    send_item(make_item(ACT_POLL, 13, 1'b1));
    now_s = now_s - 5;
    send_item(make_item(ACT_POLL, 0, 1'b0));
    send_item(make_item(ACT_POLL, 13, 1'b1));
    now_s = now_s + 7200;
    for (int k = 0; k < 5; k++) counters[0][k] = 32'sh7fff_ffff;
    counters[13][4] = 32'sh8000_0000;
    send_item(make_item(ACT_POLL, 0, 1'b0));
    send_item(make_item(ACT_POLL, 13, 1'b1));
    now_s = 32'sh7fff_fff0;
    send_item(make_item(ACT_POLL, 13, 1'b0));
    send_item(make_item(ACT_POLL, 0, 1'b1));

    // Random sessions: init the active set, then full rounds over it.
    while (items_sent < ITEM_GOAL) begin
      active.delete();
      n_active = ($urandom_range(0, 7) == 0) ? CHANNELS : $urandom_range(1, 3);
      for (int c = 0; c < CHANNELS; c++) order.push_back(c);
      order.shuffle();
      for (int i = 0; i < n_active; i++) active.push_back(order[i]);
      order.delete();
      now_s = $urandom_range(0, 100000);
      foreach (active[i]) begin
        bump_counters(active[i]);
        send_item(make_item(ACT_INIT, active[i], 1'($urandom_range(0, 1))));
      end
      repeat ((n_active == CHANNELS) ? 6 : $urandom_range(40, 90)) begin
        if (items_sent >= ITEM_GOAL) break;
        step_clock();
        order = active;
        order.shuffle();
        case ($urandom_range(0, 24))
          0: send_noise();
          1: begin
            // Re-poll without advancing the ring.
            bump_counters(order[0]);
            send_item(make_item(ACT_POLL, order[0], 1'b0));
          end
          2: begin
            // Restart one channel's base mid-session.
            bump_counters(order[0]);
            send_item(make_item(ACT_INIT, order[0], 1'($urandom_range(0, 1))));
          end
          default: ;
        endcase
        foreach (order[i]) begin
          bump_counters(order[i]);
          send_item(make_item(ACT_POLL, order[i], i == order.size() - 1));
        end
      end
    end
    in_chan.valid <= 1'b0;

    // Drain, then allow for work still in flight.
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Sent %0d transactions to valid channels: %0d polls, %0d results checked.",
             items_sent, polls_seen, results_seen);
    $display("Sessions covered ring wrap, zero and negative elapsed time and saturation.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
